// ----- sv/ffba_pkg.sv -----
// shared types and codes for the first-fit block allocator
// no dependencies; imported by the allocator top level

package ffba_pkg;

    localparam int REGION_BYTES_DEF = 16384;
    localparam int MAX_SEGMENTS_DEF = 64;
    localparam int HEADER_BYTES_DEF = 40;

    localparam int ADDR_W     = 14;
    localparam int MIN_W      = 15;
    localparam int REQ_W      = 16;
    localparam int STATUS_W   = 2;
    localparam logic [MIN_W-1:0] MIN_RESET = 15'd256;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    localparam logic [STATUS_W-1:0] ST_OK           = 2'd0;
    localparam logic [STATUS_W-1:0] ST_ALLOC_FAIL   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_INVALID_FREE = 2'd2;
    localparam logic [STATUS_W-1:0] ST_DOUBLE_FREE  = 2'd3;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN_RD,
        S_SCAN_CHK,
        S_ALLOC_FIT,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_SPLIT_WR,
        S_NEXT_RD,
        S_NEXT_CHK,
        S_PREV_RD,
        S_PREV_CHK,
        S_FINAL_WR,
        S_DONE
    } state_t;

    typedef enum logic [1:0] {
        P_SPLIT,
        P_PREV,
        P_FINAL
    } phase_t;

endpackage

// ----- sv/first_fit_block_allocator_unit.sv -----
// first-fit allocator over an address-ordered segment table, with coalescing free
// a scan reads and checks one segment at a time through the single table read port,
// and a split or merge shift moves one segment at a time with a read and a write state;
// the unit works on one item at a time
// the result register lets the next item enter while a result waits
// reset: no region open, segment count zero, minimum size 256; table contents not cleared

module first_fit_block_allocator_unit #(
    parameter int REGION_BYTES = ffba_pkg::REGION_BYTES_DEF,
    parameter int MAX_SEGMENTS = ffba_pkg::MAX_SEGMENTS_DEF,
    parameter int HEADER_BYTES = ffba_pkg::HEADER_BYTES_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic                          opcode,
    input  logic [ffba_pkg::REQ_W-1:0]    request_bytes,
    input  logic [ffba_pkg::ADDR_W-1:0]   free_address,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [ffba_pkg::ADDR_W-1:0]   grant_address,
    output logic [ffba_pkg::STATUS_W-1:0] status,
    output logic                          region_released,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [ffba_pkg::MIN_W-1:0]    cfg_data
);

    import ffba_pkg::*;

    localparam int OW  = $clog2(REGION_BYTES);
    localparam int SW  = $clog2(REGION_BYTES + 1);
    localparam int CW  = ((SW > 17) ? SW : 17) + 1;
    localparam int IW  = $clog2(MAX_SEGMENTS);
    localparam int KW  = $clog2(MAX_SEGMENTS + 1);
    localparam int DW  = OW + SW + 1;

    localparam logic [CW-1:0] HDR_C    = CW'(HEADER_BYTES);
    localparam logic [CW-1:0] REGION_C = CW'(REGION_BYTES);
    localparam logic [KW-1:0] MAX_C    = KW'(MAX_SEGMENTS);

    state_t state_reg, state_next;
    phase_t phase_reg, phase_next;

    logic              op_reg, op_next;
    logic [CW-1:0]     need_reg, need_next;
    logic [ADDR_W-1:0] addr_reg, addr_next;
    logic [IW-1:0]     idx_reg, idx_next;
    logic [KW-1:0]     k_reg, k_next;
    logic [KW-1:0]     count_reg, count_next;
    logic              present_reg, present_next;
    logic [OW-1:0]     cur_off_reg, cur_off_next;
    logic [SW-1:0]     cur_size_reg, cur_size_next;
    logic              shift_up_reg, shift_up_next;
    logic [MIN_W-1:0]  min_reg;

    logic [ADDR_W-1:0]   res_addr_reg, res_addr_next;
    logic [STATUS_W-1:0] res_status_reg, res_status_next;
    logic                res_rel_reg, res_rel_next;

    logic                out_valid_reg;
    logic [ADDR_W-1:0]   grant_reg;
    logic [STATUS_W-1:0] status_reg;
    logic                released_reg;

    logic [IW-1:0] rd_addr, wr_addr;
    logic          wr_en;
    logic [DW-1:0] rd_data, wr_data;

    logic              r_free;
    logic [SW-1:0]     r_size;
    logic [OW-1:0]     r_off;
    logic [CW-1:0]     r_data_off;
    logic [CW-1:0]     cur_data_off;
    logic [16:0]       rounded;
    logic              req_bad;
    logic [CW-1:0]     req_need;
    logic              accept;
    logic              out_free;
    logic              scan_end;
    logic              scan_hit;
    logic              split_ok;
    logic [KW-1:0]     idx_p1;
    logic [KW-1:0]     idx_k;
    logic [KW-1:0]     count_m1;
    logic              shift_last;

    ffba_seg_table #(
        .DEPTH  (MAX_SEGMENTS),
        .DATA_W (DW)
    ) u_table (
        .clk     (clk),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

    assign r_free = rd_data[0];
    assign r_size = rd_data[SW:1];
    assign r_off  = rd_data[DW-1:SW+1];

    assign r_data_off   = CW'(r_off) + HDR_C;
    assign cur_data_off = CW'(cur_off_reg) + HDR_C;

    assign rounded  = ({1'b0, request_bytes} + 17'd3) & ~17'd3;
    assign req_bad  = (request_bytes == '0) || (CW'(rounded) > REGION_C);
    assign req_need = (CW'(rounded) < CW'(min_reg)) ? CW'(min_reg) : CW'(rounded);

    assign accept   = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;
    assign scan_end = (k_reg == count_reg);
    assign scan_hit = (op_reg == OP_FREE) ? (r_data_off[ADDR_W-1:0] == addr_reg)
                                          : (r_free && (CW'(r_size) > need_reg));
    assign split_ok = (CW'(cur_size_reg) > need_reg + HDR_C) && (count_reg < MAX_C);
    assign idx_k    = KW'(idx_reg);
    assign idx_p1   = idx_k + KW'(1);
    assign count_m1 = count_reg - KW'(1);
    // count is already decremented while a removal shifts downward
    assign shift_last = shift_up_reg ? (k_reg == idx_p1) : (k_reg + KW'(1) >= count_reg);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (opcode == OP_ALLOC)
                    begin
                        if (req_bad)
                            state_next = S_DONE;
                        else if (!present_reg)
                            state_next = S_ALLOC_FIT;
                        else
                            state_next = S_SCAN_RD;
                    end
                    else if (free_address == '0 || !present_reg)
                        state_next = S_DONE;
                    else
                        state_next = S_SCAN_RD;
                end
            end
            S_SCAN_RD:
                state_next = scan_end ? S_DONE : S_SCAN_CHK;
            S_SCAN_CHK:
            begin
                if (!scan_hit)
                    state_next = S_SCAN_RD;
                else if (op_reg == OP_ALLOC)
                    state_next = S_ALLOC_FIT;
                else if (r_free)
                    state_next = S_DONE;
                else
                    state_next = S_NEXT_RD;
            end
            S_ALLOC_FIT:
            begin
                if (!split_ok)
                    state_next = S_FINAL_WR;
                else if (count_reg > idx_p1)
                    state_next = S_SHIFT_RD;
                else
                    state_next = S_SPLIT_WR;
            end
            S_SHIFT_RD:
                state_next = S_SHIFT_WR;
            S_SHIFT_WR:
            begin
                if (!shift_last)
                    state_next = S_SHIFT_RD;
                else
                begin
                    case (phase_reg)
                        P_SPLIT: state_next = S_SPLIT_WR;
                        P_PREV:  state_next = S_PREV_RD;
                        default: state_next = S_FINAL_WR;
                    endcase
                end
            end
            S_SPLIT_WR:
                state_next = S_FINAL_WR;
            S_NEXT_RD:
                state_next = (idx_p1 < count_reg) ? S_NEXT_CHK : S_PREV_RD;
            S_NEXT_CHK:
                state_next = (r_free && idx_p1 < count_m1) ? S_SHIFT_RD : S_PREV_RD;
            S_PREV_RD:
                state_next = (idx_reg == '0) ? S_FINAL_WR : S_PREV_CHK;
            S_PREV_CHK:
                state_next = (r_free && idx_k < count_m1) ? S_SHIFT_RD : S_FINAL_WR;
            S_FINAL_WR:
                state_next = S_DONE;
            S_DONE:
                state_next = out_free ? S_IDLE : S_DONE;
            default:
                state_next = S_IDLE;
        endcase
    end

    // datapath and table control
    always_comb
    begin
        phase_next      = phase_reg;
        op_next         = op_reg;
        need_next       = need_reg;
        addr_next       = addr_reg;
        idx_next        = idx_reg;
        k_next          = k_reg;
        count_next      = count_reg;
        present_next    = present_reg;
        cur_off_next    = cur_off_reg;
        cur_size_next   = cur_size_reg;
        shift_up_next   = shift_up_reg;
        res_addr_next   = res_addr_reg;
        res_status_next = res_status_reg;
        res_rel_next    = res_rel_reg;
        rd_addr         = k_reg[IW-1:0];
        wr_en           = 1'b0;
        wr_addr         = idx_reg;
        wr_data         = {cur_off_reg, cur_size_reg, op_reg};
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    op_next         = opcode;
                    need_next       = req_need;
                    addr_next       = free_address;
                    k_next          = '0;
                    res_addr_next   = '0;
                    res_status_next = ST_OK;
                    res_rel_next    = 1'b0;
                    if (opcode == OP_ALLOC)
                    begin
                        if (req_bad)
                            res_status_next = ST_ALLOC_FAIL;
                        else if (!present_reg)
                        begin
                            // open the region as one free segment
                            present_next  = 1'b1;
                            count_next    = KW'(1);
                            idx_next      = '0;
                            cur_off_next  = '0;
                            cur_size_next = SW'(REGION_BYTES);
                        end
                    end
                    else if (free_address == '0)
                        res_status_next = ST_INVALID_FREE;
                    else if (!present_reg)
                        res_status_next = ST_DOUBLE_FREE;
                end
            end
            S_SCAN_RD:
            begin
                rd_addr = k_reg[IW-1:0];
                if (scan_end)
                    res_status_next = (op_reg == OP_ALLOC) ? ST_ALLOC_FAIL : ST_INVALID_FREE;
            end
            S_SCAN_CHK:
            begin
                if (scan_hit)
                begin
                    idx_next      = k_reg[IW-1:0];
                    cur_off_next  = r_off;
                    cur_size_next = r_size;
                    if (op_reg == OP_FREE && r_free)
                        res_status_next = ST_DOUBLE_FREE;
                end
                else
                    k_next = k_reg + KW'(1);
            end
            S_ALLOC_FIT:
            begin
                shift_up_next = 1'b1;
                phase_next    = P_SPLIT;
                k_next        = count_m1;
            end
            S_SHIFT_RD:
                rd_addr = shift_up_reg ? k_reg[IW-1:0] : IW'(k_reg + KW'(1));
            S_SHIFT_WR:
            begin
                wr_en   = 1'b1;
                wr_addr = shift_up_reg ? IW'(k_reg + KW'(1)) : k_reg[IW-1:0];
                wr_data = rd_data;
                k_next  = shift_up_reg ? (k_reg - KW'(1)) : (k_reg + KW'(1));
            end
            S_SPLIT_WR:
            begin
                wr_en         = 1'b1;
                wr_addr       = IW'(idx_p1);
                wr_data       = {OW'(cur_data_off + need_reg),
                                 SW'(CW'(cur_size_reg) - need_reg - HDR_C), 1'b1};
                cur_size_next = SW'(need_reg);
                count_next    = count_reg + KW'(1);
            end
            S_NEXT_RD:
                rd_addr = IW'(idx_p1);
            S_NEXT_CHK:
            begin
                if (r_free)
                begin
                    // absorb the following segment and close the gap behind it
                    cur_size_next = SW'(CW'(cur_size_reg) + CW'(r_size) + HDR_C);
                    count_next    = count_m1;
                    k_next        = idx_p1;
                    shift_up_next = 1'b0;
                    phase_next    = P_PREV;
                end
            end
            S_PREV_RD:
                rd_addr = idx_reg - IW'(1);
            S_PREV_CHK:
            begin
                if (r_free)
                begin
                    cur_off_next  = r_off;
                    cur_size_next = SW'(CW'(cur_size_reg) + CW'(r_size) + HDR_C);
                    count_next    = count_m1;
                    idx_next      = idx_reg - IW'(1);
                    k_next        = idx_k;
                    shift_up_next = 1'b0;
                    phase_next    = P_FINAL;
                end
            end
            S_FINAL_WR:
            begin
                wr_en = 1'b1;
                if (op_reg == OP_ALLOC)
                    res_addr_next = cur_data_off[ADDR_W-1:0];
                else if (cur_size_reg == SW'(REGION_BYTES))
                begin
                    present_next = 1'b0;
                    count_next   = '0;
                    res_rel_next = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            present_reg   <= 1'b0;
            min_reg       <= MIN_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            present_reg <= present_next;
            if (cfg_valid && cfg_ready)
                min_reg <= cfg_data;
            if (state_reg == S_DONE && out_free)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        phase_reg      <= phase_next;
        op_reg         <= op_next;
        need_reg       <= need_next;
        addr_reg       <= addr_next;
        idx_reg        <= idx_next;
        k_reg          <= k_next;
        cur_off_reg    <= cur_off_next;
        cur_size_reg   <= cur_size_next;
        shift_up_reg   <= shift_up_next;
        res_addr_reg   <= res_addr_next;
        res_status_reg <= res_status_next;
        res_rel_reg    <= res_rel_next;
        if (state_reg == S_DONE && out_free)
        begin
            grant_reg    <= res_addr_reg;
            status_reg   <= res_status_reg;
            released_reg <= res_rel_reg;
        end
    end

    assign in_stall        = (state_reg != S_IDLE);
    assign out_valid       = out_valid_reg;
    assign grant_address   = grant_reg;
    assign status          = status_reg;
    assign region_released = released_reg;
    assign cfg_ready       = 1'b1;

    a_count_tracks_region: assert property (@(posedge clk) disable iff (!rst_n)
        present_reg == (count_reg != '0))
        else $error("segment count disagrees with region state");

    a_accept_starts_work: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> state_reg != S_IDLE)
        else $error("accepted item did not start the sequencer");

    a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_DONE))
        else $error("result appeared outside the done state");

    a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SPLIT_WR) |-> (count_reg < MAX_C))
        else $error("split beyond table capacity");

endmodule

// ----- sv/ffba_seg_table.sv -----
// segment table storage: one write port, one registered read port
// no dependencies; instantiated by the allocator top level

module ffba_seg_table #(
    parameter int DEPTH  = 64,
    parameter int DATA_W = 30
) (
    input  logic                     clk,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [DATA_W-1:0]        rd_data,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [DATA_W-1:0]        wr_data
);

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_data <= mem[rd_addr];
    end

endmodule
